// ===== hw/rtl/dfrc_pkg.sv =====
package dfrc_pkg;

	// byte position codes within a frame
	localparam int unsigned POS_W = 17;
	localparam logic [POS_W-1:0] POS_IDLE   = 17'd0;
	localparam logic [POS_W-1:0] POS_LEN_HI = 17'd1;
	localparam logic [POS_W-1:0] POS_LEN_LO = 17'd2;
	localparam logic [POS_W-1:0] POS_FIRST  = 17'd3;

	localparam logic [7:0] DELIM_RESET = 8'h7E;
	localparam logic [7:0] SUM_TARGET  = 8'hFF;

	// register word indexes
	localparam logic REG_DELIM = 1'b0;

	// one result word
	typedef struct packed {
		logic [15:0] frame_length;
		logic        checksum_ok;
		logic        is_end;
		logic        is_identifier;
		logic [7:0]  payload_byte;
	} dfrc_result_t;

endpackage

// ===== hw/rtl/dfrc_parse.sv =====
module dfrc_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            rx_byte,
	input  logic                  abort,
	input  logic [7:0]            start_delimiter,
	output logic                  res_valid,
	output dfrc_pkg::dfrc_result_t res
);
	import dfrc_pkg::*;

	logic [POS_W-1:0] pos_q, pos_d;
	logic [15:0]      len_q, len_d;
	logic [7:0]       sum_q, sum_d;
	logic [POS_W-1:0] pos_end;
	logic [7:0]       expect_sum;

	// checksum falls right after the last payload byte
	assign pos_end    = {1'b0, len_q} + POS_FIRST;
	assign expect_sum = SUM_TARGET - sum_q;

	// frame tracking and result for the current word
	always_comb begin
		pos_d     = pos_q;
		len_d     = len_q;
		sum_d     = sum_q;
		res_valid = 1'b0;
		res.payload_byte  = rx_byte;
		res.is_identifier = 1'b0;
		res.is_end        = 1'b0;
		res.checksum_ok   = 1'b0;
		res.frame_length  = len_q;
		priority if (abort) begin
			pos_d = POS_IDLE;
			len_d = '0;
			sum_d = '0;
		end else if (pos_q == POS_IDLE) begin
			if (rx_byte == start_delimiter) begin
				pos_d = POS_LEN_HI;
				len_d = '0;
				sum_d = '0;
			end
		end else if (pos_q == POS_LEN_HI) begin
			len_d = {rx_byte, 8'h00};
			pos_d = POS_LEN_LO;
		end else if (pos_q == POS_LEN_LO) begin
			len_d = {len_q[15:8], rx_byte};
			pos_d = POS_FIRST;
		end else if (pos_q == pos_end) begin
			res_valid       = 1'b1;
			res.is_end      = 1'b1;
			res.checksum_ok = (rx_byte == expect_sum);
			pos_d = POS_IDLE;
			len_d = '0;
			sum_d = '0;
		end else begin
			res_valid         = 1'b1;
			res.is_identifier = (pos_q == POS_FIRST);
			sum_d = sum_q + rx_byte;
			pos_d = pos_q + 1'b1;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
			len_q <= '0;
			sum_q <= '0;
		end else if (fire) begin
			pos_q <= pos_d;
			len_q <= len_d;
			sum_q <= sum_d;
		end
	end

	// checks
	a_id_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.is_identifier && res.is_end))
		else $error("identifier and end flagged together");
	a_ok_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.is_end) |-> !res.checksum_ok)
		else $error("checksum flag on payload word");
	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_valid && res.is_end) |=> (pos_q == POS_IDLE && sum_q == '0))
		else $error("frame not closed after checksum");
	a_abort_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && abort) |=> (pos_q == POS_IDLE && len_q == '0 && sum_q == '0))
		else $error("abort did not clear frame state");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q > POS_LEN_LO) |-> (pos_q <= pos_end))
		else $error("position ran past checksum");

endmodule

// ===== hw/rtl/delimited_frame_receiver_checksum.sv =====
// Delimited frame receiver: takes one received byte per word, hunts for the
// start delimiter (register 0, reset 0x7E), then reads a 16-bit big-endian
// length, that many payload bytes and one checksum byte. Each payload byte
// leaves as a word with the header length; the first one is flagged as the
// identifier. The checksum byte leaves as the last word of the frame (tlast)
// with checksum_ok set when it equals 0xFF minus the low byte of the payload
// sum. Delimiter, length bytes and aborted words give no output; an abort
// drops any partial frame. Throughput is one byte per clock while the output
// is not stalled: an input register and an output register surround the
// combinational frame logic.
module delimited_frame_receiver_checksum (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// received bytes
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	input  logic [0:0]  s_axis_tuser,  // [0] abort
	// frame output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [7:0] payload_byte, [23:8] frame_length
	output logic [1:0]  m_axis_tuser,  // [0] is_identifier, [1] checksum_ok
	output logic        m_axis_tlast   // is_end
);
	import dfrc_pkg::*;

	logic [7:0]   delim_q;
	logic         in_valid_s1;
	logic [7:0]   rx_byte_s1;
	logic         abort_s1;
	logic         out_free;
	logic         fire;
	logic         res_valid;
	dfrc_result_t res;
	logic         out_valid_q;
	dfrc_result_t out_q;

	// register port
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_DELIM) begin
			delim_q <= pwdata[7:0];
		end
	end
	assign prdata = (paddr[2] == REG_DELIM) ? {24'h0, delim_q} : 32'h0;

	// handshake flow
	assign out_free      = !out_valid_q || m_axis_tready;
	assign fire          = in_valid_s1 && out_free;
	assign s_axis_tready = !in_valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			rx_byte_s1 <= s_axis_tdata;
			abort_s1   <= s_axis_tuser[0];
		end
	end

	dfrc_parse u_parse (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.rx_byte         (rx_byte_s1),
		.abort           (abort_s1),
		.start_delimiter (delim_q),
		.res_valid       (res_valid),
		.res             (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire && res_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.frame_length, out_q.payload_byte};
	assign m_axis_tuser  = {out_q.checksum_ok, out_q.is_identifier};
	assign m_axis_tlast  = out_q.is_end;

endmodule
